@@ design/iirdf2_pkg.sv @@
// Shared types and constants for the direct form II biquad section.
// Used by iirdf2_mac, iirdf2_ctrl and iir_direct_form2_filter_unit; depends on nothing.
package iirdf2_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TAP_W      = 18;
  localparam int GAIN_W     = 28;
  localparam int DL_W       = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 28;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 52;

  localparam int DL_FRAC    = 8;
  localparam int TAP_FRAC   = 16;
  localparam int GAIN_FRAC  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_OLDEST,
    REG_NUM_RECENT,
    REG_NUM_CURRENT,
    REG_FB_OLDEST,
    REG_FB_RECENT,
    REG_INIT_GAIN
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRIME,
    ST_PLOAD,
    ST_FB,
    ST_NUM,
    ST_W,
    ST_CUR,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PRIME,
    OP_FB,
    OP_NUM,
    OP_CUR
  } op_t;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_FB,
    DST_NUM
  } dst_t;

  typedef struct packed {
    op_t  op;
    dst_t dst;
    logic prime_ld;
    logic w_ld;
    logic shift;
    logic done;
  } ctl_t;

endpackage

@@ design/iirdf2_mac.sv @@
// Shared signed multiplier with registered product and destination tag.
// Depends on iirdf2_pkg.
module iirdf2_mac (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic signed [iirdf2_pkg::MUL_A_W-1:0]      mul_a,
  input  logic signed [iirdf2_pkg::MUL_B_W-1:0]      mul_b,
  input  iirdf2_pkg::dst_t                           dst,
  output logic signed [iirdf2_pkg::PROD_W-1:0]       prod_r,
  output iirdf2_pkg::dst_t                           dst_r
);

  logic signed [iirdf2_pkg::PROD_W-1:0] prod_nxt;

  assign prod_nxt = iirdf2_pkg::PROD_W'(mul_a) * iirdf2_pkg::PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_r <= iirdf2_pkg::DST_NONE;
    end else begin
      dst_r <= dst;
    end
  end

endmodule

@@ design/iirdf2_ctrl.sv @@
// Sequencer for the biquad section: steps the shared multiplier through each transaction.
// Depends on iirdf2_pkg.
module iirdf2_ctrl #(
  parameter int ORDER = 2,
  parameter int CNT_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_first,
  input  logic               out_free,
  output logic               in_ready,
  output logic [CNT_W-1:0]   cnt_r,
  output iirdf2_pkg::ctl_t   ctl
);

  iirdf2_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               cnt_last;

  assign cnt_last = (cnt_r == CNT_W'(ORDER - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    case (state_r)
      iirdf2_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_first ? iirdf2_pkg::ST_PRIME : iirdf2_pkg::ST_FB;
        end
      end
      iirdf2_pkg::ST_PRIME: state_nxt = iirdf2_pkg::ST_PLOAD;
      iirdf2_pkg::ST_PLOAD: state_nxt = iirdf2_pkg::ST_DONE;
      iirdf2_pkg::ST_FB: begin
        if (cnt_last) begin
          state_nxt = iirdf2_pkg::ST_NUM;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      iirdf2_pkg::ST_NUM: begin
        if (cnt_last) begin
          state_nxt = iirdf2_pkg::ST_W;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      iirdf2_pkg::ST_W:     state_nxt = iirdf2_pkg::ST_CUR;
      iirdf2_pkg::ST_CUR:   state_nxt = iirdf2_pkg::ST_DRAIN;
      iirdf2_pkg::ST_DRAIN: state_nxt = iirdf2_pkg::ST_DONE;
      iirdf2_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = iirdf2_pkg::ST_IDLE;
        end
      end
      default: state_nxt = iirdf2_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    ctl          = '0;
    ctl.op       = iirdf2_pkg::OP_NONE;
    ctl.dst      = iirdf2_pkg::DST_NONE;
    case (state_r)
      iirdf2_pkg::ST_IDLE:  in_ready = 1'b1;
      iirdf2_pkg::ST_PRIME: ctl.op = iirdf2_pkg::OP_PRIME;
      iirdf2_pkg::ST_PLOAD: ctl.prime_ld = 1'b1;
      iirdf2_pkg::ST_FB: begin
        ctl.op  = iirdf2_pkg::OP_FB;
        ctl.dst = iirdf2_pkg::DST_FB;
      end
      iirdf2_pkg::ST_NUM: begin
        ctl.op  = iirdf2_pkg::OP_NUM;
        ctl.dst = iirdf2_pkg::DST_NUM;
      end
      iirdf2_pkg::ST_W: ctl.w_ld = 1'b1;
      iirdf2_pkg::ST_CUR: begin
        ctl.op    = iirdf2_pkg::OP_CUR;
        ctl.dst   = iirdf2_pkg::DST_NUM;
        ctl.shift = 1'b1;
      end
      iirdf2_pkg::ST_DRAIN: ;
      iirdf2_pkg::ST_DONE: ctl.done = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iirdf2_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ design/iir_direct_form2_filter_unit.sv @@
// Top level of the direct form II biquad section: ports, registers, delay line, datapath.
// Depends on iirdf2_pkg, iirdf2_mac and iirdf2_ctrl.
//
//   channel  handshake               payload
//   in       in_valid / in_ready     in_sample, in_first
//   out      out_valid / out_ready   out_filtered
//   cfg      cfg_wr_en               cfg_index, cfg_data
//
// A normal transaction steps through feedback, numerator, w load, current tap and drain;
// a priming one through prime and delay-line load; all use the single shared multiplier.
// The next transaction can be accepted in the cycle after the result is registered.
// Synchronous active-low reset clears taps to their defaults and the delay line to zero.
// A stalled result waits in the output register and holds the sequencer in its last step.
module iir_direct_form2_filter_unit #(
  parameter int ORDER = 2
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [iirdf2_pkg::SAMPLE_W-1:0]    in_sample,
  input  logic                                      in_first,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [iirdf2_pkg::SAMPLE_W-1:0]    out_filtered,
  input  logic                                      cfg_wr_en,
  input  logic [iirdf2_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [iirdf2_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int CNT_W = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int EXT_W = iirdf2_pkg::ACC_W + 1;
  localparam int W_SH  = iirdf2_pkg::TAP_FRAC;
  localparam int P_SH  = iirdf2_pkg::GAIN_FRAC - iirdf2_pkg::DL_FRAC;
  localparam int F_SH  = iirdf2_pkg::DL_FRAC + iirdf2_pkg::TAP_FRAC;
  localparam int DL_W  = iirdf2_pkg::DL_W;
  localparam int SMP_W = iirdf2_pkg::SAMPLE_W;

  logic signed [iirdf2_pkg::TAP_W-1:0]  num_old_r, num_rec_r, num_cur_r, fb_old_r, fb_rec_r;
  logic signed [iirdf2_pkg::GAIN_W-1:0] init_gain_r;

  logic signed [SMP_W-1:0]              sample_r;
  logic                                 first_r;
  logic signed [DL_W-1:0]               dl_r [ORDER];
  logic signed [DL_W-1:0]               w_r;
  logic signed [iirdf2_pkg::ACC_W-1:0]  fb_acc_r, num_acc_r;
  logic                                 out_valid_r;
  logic signed [SMP_W-1:0]              out_filtered_r;

  logic                                 accept;
  logic                                 out_free;
  logic [CNT_W-1:0]                     cnt;
  iirdf2_pkg::ctl_t                     ctl;

  logic signed [DL_W-1:0]               dl_sel;
  logic                                 tap_recent;
  logic signed [iirdf2_pkg::TAP_W-1:0]  fb_sel, num_sel;
  logic signed [iirdf2_pkg::MUL_A_W-1:0] mul_a;
  logic signed [iirdf2_pkg::MUL_B_W-1:0] mul_b;
  logic signed [iirdf2_pkg::PROD_W-1:0] prod;
  iirdf2_pkg::dst_t                     prod_dst;

  logic signed [EXT_W-1:0]              w_t, w_sh, p_t, p_sh, f_t, f_sh;
  logic signed [DL_W-1:0]               w_sat, p_sat;
  logic signed [SMP_W-1:0]              f_sat;

  assign accept    = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign out_valid = out_valid_r;
  assign out_filtered = out_filtered_r;

  iirdf2_ctrl #(
    .ORDER (ORDER),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_first (in_first),
    .out_free (out_free),
    .in_ready (in_ready),
    .cnt_r    (cnt),
    .ctl      (ctl)
  );

  generate
    if (ORDER == 1) begin : g_dl_one
      assign dl_sel = dl_r[0];
    end else begin : g_dl_many
      assign dl_sel = dl_r[cnt];
    end
  endgenerate

  assign tap_recent = (ORDER == 1) || (cnt == CNT_W'(ORDER - 1));
  assign fb_sel     = tap_recent ? fb_rec_r : fb_old_r;
  assign num_sel    = tap_recent ? num_rec_r : num_old_r;

  always_comb begin
    case (ctl.op)
      iirdf2_pkg::OP_PRIME: begin
        mul_a = iirdf2_pkg::MUL_A_W'(sample_r);
        mul_b = iirdf2_pkg::MUL_B_W'(init_gain_r);
      end
      iirdf2_pkg::OP_FB: begin
        mul_a = iirdf2_pkg::MUL_A_W'(dl_sel);
        mul_b = iirdf2_pkg::MUL_B_W'(fb_sel);
      end
      iirdf2_pkg::OP_NUM: begin
        mul_a = iirdf2_pkg::MUL_A_W'(dl_sel);
        mul_b = iirdf2_pkg::MUL_B_W'(num_sel);
      end
      iirdf2_pkg::OP_CUR: begin
        mul_a = iirdf2_pkg::MUL_A_W'(w_r);
        mul_b = iirdf2_pkg::MUL_B_W'(num_cur_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  iirdf2_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .dst    (ctl.dst),
    .prod_r (prod),
    .dst_r  (prod_dst)
  );

  // round half up, then saturate
  assign w_t = (EXT_W'(sample_r) <<< F_SH) - EXT_W'(fb_acc_r) + (EXT_W'(1) <<< (W_SH - 1));
  assign w_sh = w_t >>> W_SH;
  assign w_sat = ((&w_sh[EXT_W-1:DL_W-1]) || !(|w_sh[EXT_W-1:DL_W-1])) ? w_sh[DL_W-1:0] :
                 (w_sh[EXT_W-1] ? {1'b1, {(DL_W-1){1'b0}}} : {1'b0, {(DL_W-1){1'b1}}});

  assign p_t = EXT_W'(prod) + (EXT_W'(1) <<< (P_SH - 1));
  assign p_sh = p_t >>> P_SH;
  assign p_sat = ((&p_sh[EXT_W-1:DL_W-1]) || !(|p_sh[EXT_W-1:DL_W-1])) ? p_sh[DL_W-1:0] :
                 (p_sh[EXT_W-1] ? {1'b1, {(DL_W-1){1'b0}}} : {1'b0, {(DL_W-1){1'b1}}});

  assign f_t = EXT_W'(num_acc_r) + (EXT_W'(1) <<< (F_SH - 1));
  assign f_sh = f_t >>> F_SH;
  assign f_sat = ((&f_sh[EXT_W-1:SMP_W-1]) || !(|f_sh[EXT_W-1:SMP_W-1])) ? f_sh[SMP_W-1:0] :
                 (f_sh[EXT_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_old_r   <= '0;
      num_rec_r   <= '0;
      num_cur_r   <= iirdf2_pkg::TAP_W'(1 << iirdf2_pkg::TAP_FRAC);
      fb_old_r    <= '0;
      fb_rec_r    <= '0;
      init_gain_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        iirdf2_pkg::REG_NUM_OLDEST:  num_old_r   <= cfg_data[iirdf2_pkg::TAP_W-1:0];
        iirdf2_pkg::REG_NUM_RECENT:  num_rec_r   <= cfg_data[iirdf2_pkg::TAP_W-1:0];
        iirdf2_pkg::REG_NUM_CURRENT: num_cur_r   <= cfg_data[iirdf2_pkg::TAP_W-1:0];
        iirdf2_pkg::REG_FB_OLDEST:   fb_old_r    <= cfg_data[iirdf2_pkg::TAP_W-1:0];
        iirdf2_pkg::REG_FB_RECENT:   fb_rec_r    <= cfg_data[iirdf2_pkg::TAP_W-1:0];
        iirdf2_pkg::REG_INIT_GAIN:   init_gain_r <= cfg_data[iirdf2_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
      first_r  <= in_first;
    end
    if (ctl.w_ld) begin
      w_r <= w_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fb_acc_r  <= '0;
      num_acc_r <= '0;
    end else begin
      if (prod_dst == iirdf2_pkg::DST_FB) begin
        fb_acc_r <= fb_acc_r + iirdf2_pkg::ACC_W'(prod);
      end
      if (prod_dst == iirdf2_pkg::DST_NUM) begin
        num_acc_r <= num_acc_r + iirdf2_pkg::ACC_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ORDER; i++) begin
        dl_r[i] <= '0;
      end
    end else if (ctl.prime_ld) begin
      for (int i = 0; i < ORDER; i++) begin
        dl_r[i] <= p_sat;
      end
    end else if (ctl.shift) begin
      for (int i = 0; i < ORDER - 1; i++) begin
        dl_r[i] <= dl_r[i+1];
      end
      dl_r[ORDER-1] <= w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      out_filtered_r <= first_r ? sample_r : f_sat;
    end
  end

endmodule

@@ tb/iir_direct_form2_filter_unit_test.sv @@
// Self-checking testbench for the direct form II biquad section: drives samples and
// coefficient writes, predicts each filtered result and compares it at the output.
// Depends on iirdf2_pkg and the iir_direct_form2_filter_unit RTL.
module iir_direct_form2_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import iirdf2_pkg::*;

  localparam int     ORDER       = 2;
  localparam int     LONG_HOLD   = 300;
  localparam int     PHASE_ITEMS = 100;
  localparam int     NUM_PHASES  = 8;
  localparam longint DL_MAX      = (longint'(1) <<< 31) - 1;
  localparam longint DL_MIN      = -(longint'(1) <<< 31);
  localparam longint OUT_MAX     = 32767;
  localparam longint OUT_MIN     = -32768;
  localparam logic [CFG_DATA_W-1:0] TAP_MAX  = CFG_DATA_W'(18'h1FFFF);
  localparam logic [CFG_DATA_W-1:0] TAP_MIN  = CFG_DATA_W'(18'h20000);
  localparam logic [CFG_DATA_W-1:0] GAIN_MAX = 28'h7FFFFFF;
  localparam logic [CFG_DATA_W-1:0] GAIN_MIN = 28'h8000000;

  class filter_scoreboard;
    longint num_tap[2];
    longint fb_tap[2];
    longint num_cur;
    longint gain;
    longint dline[2];
    logic signed [SAMPLE_W-1:0] expected_q[$];
    int errors;
    int checked;
    int primed;
    int noted;

    function new();
      num_tap = '{0, 0};
      fb_tap  = '{0, 0};
      num_cur = 65536;
      gain    = 0;
      dline   = '{0, 0};
      errors  = 0;
      checked = 0;
      primed  = 0;
      noted   = 0;
    endfunction

    function longint rnd(longint v, int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_NUM_OLDEST:  num_tap[0] = longint'(signed'(data[TAP_W-1:0]));
        REG_NUM_RECENT:  num_tap[1] = longint'(signed'(data[TAP_W-1:0]));
        REG_NUM_CURRENT: num_cur    = longint'(signed'(data[TAP_W-1:0]));
        REG_FB_OLDEST:   fb_tap[0]  = longint'(signed'(data[TAP_W-1:0]));
        REG_FB_RECENT:   fb_tap[1]  = longint'(signed'(data[TAP_W-1:0]));
        REG_INIT_GAIN:   gain       = longint'(signed'(data[GAIN_W-1:0]));
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic f);
      longint x, p, fb_sum, num_sum, w, d, res;
      int c;
      x = s;
      noted++;
      if (f) begin
        primed++;
        p = clip(rnd(x * gain, DL_FRAC), DL_MIN, DL_MAX);
        for (int i = 0; i < ORDER; i++) dline[i & 1] = p;
        res = x;
      end else begin
        fb_sum  = 0;
        num_sum = 0;
        for (int i = 0; i < ORDER; i++) begin
          d = dline[i & 1];
          c = (2 - ORDER + i) & 1;
          num_sum += d * num_tap[c];
          fb_sum  += d * fb_tap[c];
        end
        w = clip(rnd((x <<< 24) - fb_sum, TAP_FRAC), DL_MIN, DL_MAX);
        for (int i = 0; i < ORDER - 1; i++) dline[i & 1] = dline[(i + 1) & 1];
        dline[(ORDER - 1) & 1] = w;
        num_sum += num_cur * w;
        res = clip(rnd(num_sum, 24), OUT_MIN, OUT_MAX);
      end
      expected_q.push_back(res[SAMPLE_W-1:0]);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_filtered(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing outstanding", got));
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (got !== want)
          report_mismatch($sformatf("filtered %0d, expected %0d", got, want));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  in_sample = '0;
  logic                        in_first = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]  out_filtered;
  logic                        cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  filter_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit long_hold_req = 1'b0;
  int coeff_sets = 1;

  iir_direct_form2_filter_unit #(.ORDER(ORDER)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .in_first     (in_first),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_filtered (out_filtered),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_sample(in_sample, in_first);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_filtered(out_filtered);
  end

  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_item(input logic signed [SAMPLE_W-1:0] s, input logic f);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    in_first  <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_taps(input logic [CFG_DATA_W-1:0] n_old, n_rec, n_cur,
                              input logic [CFG_DATA_W-1:0] f_old, f_rec, g);
    write_reg(REG_NUM_OLDEST, n_old);
    write_reg(REG_NUM_RECENT, n_rec);
    write_reg(REG_NUM_CURRENT, n_cur);
    write_reg(REG_FB_OLDEST, f_old);
    write_reg(REG_FB_RECENT, f_rec);
    write_reg(REG_INIT_GAIN, g);
    coeff_sets++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_tap(bit gentle);
    int m;
    m = gentle ? 1 : $urandom_range(4);
    case (m)
      0: return CFG_DATA_W'($urandom);
      1: return CFG_DATA_W'($signed($urandom_range(32768)) - 16384);
      2: return TAP_MAX;
      3: return TAP_MIN;
      default: return CFG_DATA_W'($signed($urandom_range(262143)) - 131072);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_gain();
    case ($urandom_range(3))
      0: return CFG_DATA_W'($urandom);
      1: return GAIN_MAX;
      2: return GAIN_MIN;
      default: return CFG_DATA_W'($signed($urandom_range(262144)) - 131072);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SAMPLE_W'($signed($urandom_range(512)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    bit gentle;
    int guard;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(16'sh7FFF, 1'b1);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh0000, 1'b0);
    send_item(-16'sd1, 1'b0);
    wait_idle();
    for (int r = REG_INIT_GAIN + 1; r < 2 ** CFG_IDX_W; r++)
      write_reg(CFG_IDX_W'(r), CFG_DATA_W'($urandom));
    send_item(16'sd1234, 1'b0);
    wait_idle();

    program_taps(TAP_MAX, TAP_MAX, TAP_MAX, TAP_MAX, TAP_MAX, GAIN_MAX);
    send_item(16'sh8000, 1'b1);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b1);
    send_item(16'sd1, 1'b0);
    wait_idle();

    program_taps(TAP_MIN, TAP_MIN, TAP_MIN, TAP_MIN, TAP_MIN, GAIN_MIN);
    send_item(16'sh7FFF, 1'b1);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh8000, 1'b1);
    send_item(16'sh0000, 1'b0);
    wait_idle();

    program_taps(28'hFFC4000, 28'h0030000, 28'hAA10000, 28'h5538000, 28'hFFF0000,
                 28'h0010000);
    send_item(16'sd100, 1'b1);
    send_item(16'sh7FFF, 1'b0);
    send_item(-16'sd300, 1'b0);
    send_item(16'sd5, 1'b0);
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
        default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      gentle = (ph % 2 == 0);
      program_taps(rand_tap(1'b0), rand_tap(1'b0), rand_tap(gentle), rand_tap(gentle),
                   rand_tap(gentle), rand_gain());
      if (ph == 4) long_hold_req = 1'b1;
      send_item(rand_sample(), 1'b1);
      for (int n = 1; n < PHASE_ITEMS; n++)
        send_item(rand_sample(), ($urandom_range(99) < 6));
      wait_idle();
    end

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    guard = 0;
    while (sb.pending() > 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    $display("covered %0d samples (%0d priming) over %0d coefficient sets", sb.noted,
             sb.primed, coeff_sets);
    $display("%0d results checked, %0d mismatches, %0d outstanding", sb.checked,
             sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/iirdf2_pkg.sv
design/iirdf2_mac.sv
design/iirdf2_ctrl.sv
design/iir_direct_form2_filter_unit.sv
tb/iir_direct_form2_filter_unit_test.sv
